>>> src/voxel_sphere_and_shell_carver_assert.svh
// Assertion macros shared by the voxel carver RTL.
`ifndef VOXEL_SPHERE_AND_SHELL_CARVER_ASSERT_SVH
`define VOXEL_SPHERE_AND_SHELL_CARVER_ASSERT_SVH
`ifndef SYNTH
`define VSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define VSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VSC_ASSERT_IMP(lbl, ante, cons, msg)
`define VSC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/vscc_pkg.sv
// Shared types and constants of the voxel sphere and shell carver.
`timescale 1ns / 1ps
`default_nettype none
package vscc_pkg;

  localparam int PosW   = 7;
  localparam int CoordW = 8;
  localparam int OffW   = 6;
  localparam int RadW   = 5;
  localparam int SqW    = 9;
  localparam int D2W    = 10;
  localparam int Q2W    = 16;
  localparam int ExtW   = 6;
  localparam int IdxW   = 3 * ExtW;

  typedef enum logic [1:0] {
    CMD_SOLID = 2'd0,
    CMD_SHELL = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic   vld;
    logic   last;
    logic   keep;
    cmd_e   cmd;
    coord_t z;
    coord_t y;
    coord_t x;
  } cand_t;

  typedef struct packed {
    logic done;
    logic wrote;
    logic hit;
    logic occ;
  } ret_t;

  function automatic logic in_range(coord_t c, logic [ExtW-1:0] e);
    return !c[CoordW-1] && ({1'b0, c[CoordW-2:0]} < {{(CoordW-ExtW){1'b0}}, e});
  endfunction

endpackage
`default_nettype wire

>>> src/vscc_sweep.sv
// Offset sweep over the bounding box and distance test of each candidate.
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_sphere_and_shell_carver_assert.svh"
module vscc_sweep import vscc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  cmd_e                   cmd_i,
  input  logic signed [PosW-1:0] cz_i,
  input  logic signed [PosW-1:0] cy_i,
  input  logic signed [PosW-1:0] cx_i,
  input  logic [RadW-1:0]        zb_i,
  input  logic [RadW-1:0]        rb_i,
  input  logic [SqW-1:0]         rr2_i,
  input  logic [Q2W-1:0]         outer2_i,
  input  logic [Q2W-1:0]         inner2_i,
  output cand_t                  cand_o
);

  logic                   run_q, run_d;
  logic signed [OffW-1:0] dz_q, dz_d, dy_q, dy_d, dx_q, dx_d;
  logic signed [OffW-1:0] zb_s, rb_s;
  logic                   last;

  logic signed [2*OffW-1:0] pz, py, px;
  coord_t                   zc, yc, xc;

  logic               s1_vld_q, s1_last_q;
  logic [SqW-1:0]     sqz_q, sqy_q, sqx_q;
  coord_t             z1_q, y1_q, x1_q;
  logic [D2W-1:0]     d2;
  logic [D2W+7:0]     d2_q4;
  logic               keep;
  cand_t              cand_q;

  assign zb_s = signed'({1'b0, zb_i});
  assign rb_s = signed'({1'b0, rb_i});
  assign last = run_q && (dx_q == rb_s) && (dy_q == rb_s) && (dz_q == zb_s);

  always_comb begin
    run_d = run_q;
    dz_d  = dz_q;
    dy_d  = dy_q;
    dx_d  = dx_q;
    if (start_i) begin
      run_d = 1'b1;
      dz_d  = -zb_s;
      dy_d  = -rb_s;
      dx_d  = -rb_s;
    end else if (run_q) begin
      if (dx_q != rb_s) begin
        dx_d = dx_q + 6'sd1;
      end else begin
        dx_d = -rb_s;
        if (dy_q != rb_s) begin
          dy_d = dy_q + 6'sd1;
        end else begin
          dy_d = -rb_s;
          if (dz_q != zb_s) begin
            dz_d = dz_q + 6'sd1;
          end else begin
            run_d = 1'b0;
          end
        end
      end
    end
  end

  assign pz = dz_q * dz_q;
  assign py = dy_q * dy_q;
  assign px = dx_q * dx_q;
  assign zc = {cz_i[PosW-1], cz_i} + {{(CoordW-OffW){dz_q[OffW-1]}}, dz_q};
  assign yc = {cy_i[PosW-1], cy_i} + {{(CoordW-OffW){dy_q[OffW-1]}}, dy_q};
  assign xc = {cx_i[PosW-1], cx_i} + {{(CoordW-OffW){dx_q[OffW-1]}}, dx_q};

  assign d2    = {1'b0, sqz_q} + {1'b0, sqy_q} + {1'b0, sqx_q};
  assign d2_q4 = {d2, 8'b0};

  always_comb begin
    case (cmd_i)
      CMD_SOLID: keep = (d2 <= {1'b0, rr2_i});
      CMD_SHELL: keep = (d2_q4 >= {2'b0, inner2_i}) && (d2_q4 <= {2'b0, outer2_i});
      CMD_READ:  keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      dz_q      <= '0;
      dy_q      <= '0;
      dx_q      <= '0;
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      cand_q    <= '0;
    end else begin
      run_q         <= run_d;
      dz_q          <= dz_d;
      dy_q          <= dy_d;
      dx_q          <= dx_d;
      s1_vld_q      <= run_q;
      s1_last_q     <= last;
      cand_q.vld    <= s1_vld_q;
      cand_q.last   <= s1_last_q;
      cand_q.keep   <= s1_vld_q && keep;
      cand_q.cmd    <= cmd_i;
      cand_q.z      <= z1_q;
      cand_q.y      <= y1_q;
      cand_q.x      <= x1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqz_q <= pz[SqW-1:0];
    sqy_q <= py[SqW-1:0];
    sqx_q <= px[SqW-1:0];
    z1_q  <= zc;
    y1_q  <= yc;
    x1_q  <= xc;
  end

  assign cand_o = cand_q;

  `VSC_ASSERT_NXT(a_sweep_stops_after_last, last && !start_i, !run_q, "sweep ran past its last candidate")

endmodule
`default_nettype wire

>>> src/vscc_addr.sv
// Bounds check and linear voxel address of each candidate, two stages.
`timescale 1ns / 1ps
`default_nettype none
module vscc_addr import vscc_pkg::*; #(
  parameter int DIM_MAX = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  cand_t                                         cand_i,
  input  logic [ExtW-1:0]                               ez_i,
  input  logic [ExtW-1:0]                               ey_i,
  input  logic [ExtW-1:0]                               ex_i,
  output cand_t                                         cand_o,
  output logic [$clog2(DIM_MAX*DIM_MAX*DIM_MAX)-1:0]    addr_o
);

  localparam int Depth = DIM_MAX * DIM_MAX * DIM_MAX;
  localparam int AW    = $clog2(Depth);

  logic               inb;
  logic [2*ExtW-1:0]  zy_d, zy_q;
  logic [ExtW-1:0]    xa_q;
  logic [IdxW-1:0]    idx_d;
  cand_t              a_q, b_q;
  logic [AW-1:0]      addr_q;

  assign inb   = in_range(cand_i.z, ez_i) && in_range(cand_i.y, ey_i) &&
                 in_range(cand_i.x, ex_i);
  assign zy_d  = cand_i.z[ExtW-1:0] * ey_i + {{ExtW{1'b0}}, cand_i.y[ExtW-1:0]};
  assign idx_d = zy_q * ex_i + {{(2*ExtW){1'b0}}, xa_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else begin
      a_q      <= cand_i;
      a_q.keep <= cand_i.keep && inb;
      b_q      <= a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    zy_q   <= zy_d;
    xa_q   <= cand_i.x[ExtW-1:0];
    addr_q <= AW'(idx_d);
  end

  assign cand_o = b_q;
  assign addr_o = addr_q;

endmodule
`default_nettype wire

>>> src/vscc_store.sv
// Label and occupancy memory with read-modify-write and clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_sphere_and_shell_carver_assert.svh"
module vscc_store import vscc_pkg::*; #(
  parameter int DIM_MAX    = 32,
  parameter int LABEL_BITS = 8
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  cand_t                                         cand_i,
  input  logic [$clog2(DIM_MAX*DIM_MAX*DIM_MAX)-1:0]    addr_i,
  input  logic [LABEL_BITS-1:0]                         label_i,
  output logic                                          clr_busy_o,
  output ret_t                                          ret_o,
  output logic [LABEL_BITS-1:0]                         rd_label_o
);

  localparam int Depth = DIM_MAX * DIM_MAX * DIM_MAX;
  localparam int AW    = $clog2(Depth);
  localparam logic [AW-1:0] LastEntry = AW'(Depth - 1);

  logic [LABEL_BITS:0]   vox_mem [Depth];
  logic [LABEL_BITS:0]   rdata_q;
  logic                  clr_q;
  logic [AW-1:0]         cnt_q;
  cand_t                 m1_q;
  logic [AW-1:0]         m1_addr_q;
  logic                  m1_we;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [LABEL_BITS:0]   wd;
  ret_t                  ret_q;
  logic [LABEL_BITS-1:0] rd_label_q;

  assign m1_we = m1_q.vld && m1_q.keep &&
                 ((m1_q.cmd == CMD_SOLID) ||
                  ((m1_q.cmd == CMD_SHELL) && !rdata_q[LABEL_BITS]));

  always_comb begin
    if (clr_q) begin
      we = 1'b1;
      wa = cnt_q;
      wd = '0;
    end else begin
      we = m1_we;
      wa = m1_addr_q;
      wd = {1'b1, label_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      vox_mem[wa] <= wd;
    end
    rdata_q <= vox_mem[addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      cnt_q <= '0;
      m1_q  <= '0;
      ret_q <= '0;
    end else begin
      if (clr_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastEntry) begin
          clr_q <= 1'b0;
        end
      end
      m1_q        <= cand_i;
      ret_q.done  <= m1_q.vld && m1_q.last;
      ret_q.wrote <= m1_we;
      ret_q.hit   <= m1_q.keep;
      ret_q.occ   <= rdata_q[LABEL_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    m1_addr_q  <= addr_i;
    rd_label_q <= rdata_q[LABEL_BITS-1:0];
  end

  assign clr_busy_o = clr_q;
  assign ret_o      = ret_q;
  assign rd_label_o = rd_label_q;

  `VSC_ASSERT_IMP(a_no_rw_same_entry, m1_we && cand_i.vld && cand_i.keep, m1_addr_q != addr_i, "read of an entry under write")
  `VSC_ASSERT_IMP(a_idle_while_clearing, clr_q, !cand_i.vld, "candidate during clearing pass")

endmodule
`default_nettype wire

>>> src/voxel_sphere_and_shell_carver.sv
// Top level of the voxel sphere and shell carver: register port, control and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_sphere_and_shell_carver_assert.svh"
// Carves solid spheres and hollow shells into a DIM_MAX^3 label volume with an occupancy bit
// per voxel, and reads single voxels back. One command is worked at a time; the next command
// is taken while the previous result waits in the output register. A carve visits one
// candidate voxel per cycle through a read-modify-write of the voxel memory, which has one
// read and one write port: a solid carve visits (2*Rz+1)*(2*R+1)^2 candidates, a shell
// (2*B+1)^3 with B = min(ceil(outer), RADIUS_MAX), up to 29791 at the default radius limit.
// After reset a clearing pass zeroes all DIM_MAX^3 entries (32768 by default) of the volume;
// no command is taken until it ends, while register writes are taken at any time.
module voxel_sphere_and_shell_carver import vscc_pkg::*; #(
  parameter int DIM_MAX    = 32,
  parameter int RADIUS_MAX = 15,
  parameter int LABEL_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [6:0]  pos_z_i,
  input  logic [6:0]  pos_y_i,
  input  logic [6:0]  pos_x_i,
  input  logic [7:0]  radius_q4_i,
  input  logic [7:0]  second_q4_i,
  input  logic [7:0]  fill_label_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [7:0]  read_label_o,
  output logic        read_occupied_o,
  output logic [14:0] voxels_written_o,
  output logic [15:0] shell_total_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int Depth = DIM_MAX * DIM_MAX * DIM_MAX;
  localparam int AW    = $clog2(Depth);
  localparam int RLim  = (RADIUS_MAX < 16) ? RADIUS_MAX : 16;
  localparam int DLim  = (DIM_MAX > 63) ? 63 : DIM_MAX;
  localparam logic [RadW-1:0] RCap = RadW'(RLim);
  localparam logic [ExtW-1:0] DCap = ExtW'(DLim);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SETUP = 5'b00100,
    S_RUN   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    REG_EXT_Z = 2'd0,
    REG_EXT_Y = 2'd1,
    REG_EXT_X = 2'd2
  } reg_e;

  state_e state_q, state_d;

  logic [ExtW-1:0] ext_z_q, ext_y_q, ext_x_q;
  logic [ExtW-1:0] ez, ey, ex;
  logic            cfg_wr;

  cmd_e                   cmd_q;
  logic signed [PosW-1:0] cz_q, cy_q, cx_q;
  logic [7:0]             rq_q, sq_q;
  logic [LABEL_BITS-1:0]  lab_q;

  logic [8:0]      rr_sum, rz_sum, bd_sum;
  logic [RadW-1:0] rr_c, rz_c, bd_c;
  logic [7:0]      inner;
  logic [Q2W-1:0]  outer2_d, inner2_d, outer2_q, inner2_q;
  logic [SqW-1:0]  rr2_d, rr2_q;
  logic [RadW-1:0] zb_d, rb_d, zb_q, rb_q;
  logic            start_q;

  logic            accept;
  logic            load_out;
  logic            res_status_q;
  logic            res_occ_q;
  logic [LABEL_BITS-1:0] res_label_q;
  logic [14:0]     wr_cnt_q;
  logic [15:0]     shell_cnt_q, shell_next;

  logic            out_valid_q;
  logic            status_q, occ_q;
  logic [7:0]      label_q;
  logic [14:0]     written_q;
  logic [15:0]     total_q;

  cand_t                 sw_cand, ad_cand;
  logic [AW-1:0]         ad_addr;
  logic                  clr_busy;
  ret_t                  ret;
  logic [LABEL_BITS-1:0] rd_label;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_z_q <= 6'd32;
      ext_y_q <= 6'd32;
      ext_x_q <= 6'd32;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[3:2]))
        REG_EXT_Z: ext_z_q <= pwdata[ExtW-1:0];
        REG_EXT_Y: ext_y_q <= pwdata[ExtW-1:0];
        REG_EXT_X: ext_x_q <= pwdata[ExtW-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_EXT_Z: prdata = {{(32-ExtW){1'b0}}, ext_z_q};
      REG_EXT_Y: prdata = {{(32-ExtW){1'b0}}, ext_y_q};
      REG_EXT_X: prdata = {{(32-ExtW){1'b0}}, ext_x_q};
      default:   prdata = '0;
    endcase
  end

  assign ez = (ext_z_q > DCap) ? DCap : ext_z_q;
  assign ey = (ext_y_q > DCap) ? DCap : ext_y_q;
  assign ex = (ext_x_q > DCap) ? DCap : ext_x_q;

  // command setup
  assign rr_sum   = {1'b0, rq_q} + 9'd8;
  assign rz_sum   = {1'b0, sq_q} + 9'd8;
  assign bd_sum   = {1'b0, rq_q} + 9'd15;
  assign rr_c     = (rr_sum[8:4] > RCap) ? RCap : rr_sum[8:4];
  assign rz_c     = (rz_sum[8:4] > RCap) ? RCap : rz_sum[8:4];
  assign bd_c     = (bd_sum[8:4] > RCap) ? RCap : bd_sum[8:4];
  assign inner    = (rq_q > sq_q) ? (rq_q - sq_q) : 8'd0;
  assign outer2_d = rq_q * rq_q;
  assign inner2_d = inner * inner;
  assign rr2_d    = rr_c * rr_c;

  always_comb begin
    case (cmd_q)
      CMD_SOLID: begin
        zb_d = rz_c;
        rb_d = rr_c;
      end
      CMD_SHELL: begin
        zb_d = bd_c;
        rb_d = bd_c;
      end
      default: begin
        zb_d = '0;
        rb_d = '0;
      end
    endcase
  end

  // control
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign shell_next = shell_cnt_q + {15'd0, (cmd_q == CMD_SHELL)};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (!clr_busy) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          state_d = (cmd_e'(command_i) == CMD_NONE) ? S_DONE : S_SETUP;
        end
      end
      S_SETUP: state_d = S_RUN;
      S_RUN:   if (ret.done) state_d = S_DONE;
      S_DONE:  if (load_out) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      start_q      <= 1'b0;
      cmd_q        <= CMD_NONE;
      res_status_q <= 1'b0;
      res_occ_q    <= 1'b0;
      wr_cnt_q     <= '0;
      shell_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= (state_q == S_SETUP);
      if (accept) begin
        cmd_q        <= cmd_e'(command_i);
        res_status_q <= 1'b0;
        res_occ_q    <= 1'b0;
        wr_cnt_q     <= '0;
      end
      if ((state_q == S_RUN) && ret.wrote) begin
        wr_cnt_q <= wr_cnt_q + 15'd1;
      end
      if ((state_q == S_RUN) && ret.done && (cmd_q == CMD_READ)) begin
        res_status_q <= !ret.hit;
        res_occ_q    <= ret.hit && ret.occ;
      end
      if (load_out) begin
        shell_cnt_q <= shell_next;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cz_q        <= pos_z_i;
      cy_q        <= pos_y_i;
      cx_q        <= pos_x_i;
      rq_q        <= radius_q4_i;
      sq_q        <= second_q4_i;
      lab_q       <= LABEL_BITS'(fill_label_i);
      res_label_q <= '0;
    end
    if ((state_q == S_RUN) && ret.done && (cmd_q == CMD_READ) && ret.hit) begin
      res_label_q <= rd_label;
    end
    if (state_q == S_SETUP) begin
      zb_q     <= zb_d;
      rb_q     <= rb_d;
      rr2_q    <= rr2_d;
      outer2_q <= outer2_d;
      inner2_q <= inner2_d;
    end
    if (load_out) begin
      status_q  <= res_status_q;
      label_q   <= 8'(res_label_q);
      occ_q     <= res_occ_q;
      written_q <= wr_cnt_q;
      total_q   <= shell_next;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign read_label_o     = label_q;
  assign read_occupied_o  = occ_q;
  assign voxels_written_o = written_q;
  assign shell_total_o    = total_q;

  vscc_sweep u_sweep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .cmd_i    (cmd_q),
    .cz_i     (cz_q),
    .cy_i     (cy_q),
    .cx_i     (cx_q),
    .zb_i     (zb_q),
    .rb_i     (rb_q),
    .rr2_i    (rr2_q),
    .outer2_i (outer2_q),
    .inner2_i (inner2_q),
    .cand_o   (sw_cand)
  );

  vscc_addr #(
    .DIM_MAX (DIM_MAX)
  ) u_addr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cand_i (sw_cand),
    .ez_i   (ez),
    .ey_i   (ey),
    .ex_i   (ex),
    .cand_o (ad_cand),
    .addr_o (ad_addr)
  );

  vscc_store #(
    .DIM_MAX    (DIM_MAX),
    .LABEL_BITS (LABEL_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cand_i     (ad_cand),
    .addr_i     (ad_addr),
    .label_i    (lab_q),
    .clr_busy_o (clr_busy),
    .ret_o      (ret),
    .rd_label_o (rd_label)
  );

  `VSC_ASSERT_IMP(a_no_accept_while_clearing, accept, !clr_busy, "command taken during clearing pass")
  `VSC_ASSERT_IMP(a_done_only_in_run, ret.done, state_q == S_RUN, "sweep finished outside a command")

endmodule
`default_nettype wire

>>> test/tb_voxel_sphere_and_shell_carver.sv
// Self-checking testbench for the voxel sphere and shell carver: volume mirror and handshakes.
`timescale 1ns / 1ps
module tb_voxel_sphere_and_shell_carver;
  import vscc_pkg::*;

  localparam int DIM          = 32;
  localparam int VOLUME       = DIM * DIM * DIM;
  localparam int RADIUS_LIMIT = 15;
  localparam int REG_EXTENT_Z = 0;
  localparam int REG_EXTENT_Y = 1;
  localparam int REG_EXTENT_X = 2;
  localparam int STALL_LIMIT  = 250000;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 3000;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    cmd_e       cmd;
    logic [6:0] pz;
    logic [6:0] py;
    logic [6:0] px;
    logic [7:0] radius;
    logic [7:0] extra;
    logic [7:0] fill;
  } voxel_cmd_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  label;
    logic        occ;
    logic [14:0] written;
    logic [15:0] shell_total;
  } voxel_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i       = '0;
  logic [6:0]  pos_z_i         = '0;
  logic [6:0]  pos_y_i         = '0;
  logic [6:0]  pos_x_i         = '0;
  logic [7:0]  radius_q4_i     = '0;
  logic [7:0]  second_q4_i     = '0;
  logic [7:0]  fill_label_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic        status_o;
  logic [7:0]  read_label_o;
  logic        read_occupied_o;
  logic [14:0] voxels_written_o;
  logic [15:0] shell_total_o;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [3:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;

  voxel_sphere_and_shell_carver dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .pos_z_i, .pos_y_i, .pos_x_i,
    .radius_q4_i, .second_q4_i, .fill_label_i, .out_valid_o, .out_ready_i, .status_o,
    .read_label_o, .read_occupied_o, .voxels_written_o, .shell_total_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bit [7:0]      label_mirror [VOLUME];
  bit            occupied_mirror [VOLUME];
  logic [15:0]   shell_tally = '0;
  logic [5:0]    ext_z = 6'd32;
  logic [5:0]    ext_y = 6'd32;
  logic [5:0]    ext_x = 6'd32;

  voxel_cmd_t    cmd_backlog [$];
  voxel_result_t awaited_results [$];
  voxel_cmd_t    offered = '0;
  bit            in_taken;
  int            send_gap_pct = 0;
  int            recv_gap_pct = 0;
  int            results_seen = 0;
  int            mismatches = 0;
  int            stall_cycles = 0;
  int            hold_left = 0;
  bit            hold_done = 1'b0;
  int            n_solid = 0, n_shell = 0, n_read = 0, n_unused = 0, n_settings = 0;
  int            recent_z = 16, recent_y = 16, recent_x = 16;

  function automatic int effective(logic [5:0] e);
    return (e > DIM) ? DIM : int'(e);
  endfunction

  function automatic int limit_radius(int r);
    return (r > RADIUS_LIMIT) ? RADIUS_LIMIT : r;
  endfunction

  function automatic bit locate_voxel(int z, int y, int x, output int idx);
    int ez, ey, ex;
    ez = effective(ext_z);
    ey = effective(ext_y);
    ex = effective(ext_x);
    idx = 0;
    if (z < 0 || z >= ez || y < 0 || y >= ey || x < 0 || x >= ex) return 1'b0;
    idx = (z * ey + y) * ex + x;
    return 1'b1;
  endfunction

  function automatic voxel_result_t carve_or_read(voxel_cmd_t c);
    voxel_result_t res;
    int cz, cy, cx, rr, rz, bound, inner, idx, d2, outer2, inner2, count;
    res = '0;
    count = 0;
    cz = $signed(c.pz);
    cy = $signed(c.py);
    cx = $signed(c.px);
    case (c.cmd)
      CMD_SOLID: begin
        rr = limit_radius((int'(c.radius) + 8) >> 4);
        rz = limit_radius((int'(c.extra) + 8) >> 4);
        for (int dz = -rz; dz <= rz; dz++)
          for (int dy = -rr; dy <= rr; dy++)
            for (int dx = -rr; dx <= rr; dx++) begin
              if (dz * dz + dy * dy + dx * dx > rr * rr) continue;
              if (!locate_voxel(cz + dz, cy + dy, cx + dx, idx)) continue;
              label_mirror[idx] = c.fill;
              occupied_mirror[idx] = 1'b1;
              count++;
            end
      end
      CMD_SHELL: begin
        inner  = (c.radius > c.extra) ? int'(c.radius) - int'(c.extra) : 0;
        outer2 = int'(c.radius) * int'(c.radius);
        inner2 = inner * inner;
        bound  = limit_radius((int'(c.radius) + 15) >> 4);
        for (int dz = -bound; dz <= bound; dz++)
          for (int dy = -bound; dy <= bound; dy++)
            for (int dx = -bound; dx <= bound; dx++) begin
              d2 = (dz * dz + dy * dy + dx * dx) * 256;
              if (d2 < inner2 || d2 > outer2) continue;
              if (!locate_voxel(cz + dz, cy + dy, cx + dx, idx)) continue;
              if (occupied_mirror[idx]) continue;
              label_mirror[idx] = c.fill;
              occupied_mirror[idx] = 1'b1;
              count++;
            end
        shell_tally = shell_tally + 16'd1;
      end
      CMD_READ: begin
        if (locate_voxel(cz, cy, cx, idx)) begin
          res.label = label_mirror[idx];
          res.occ   = occupied_mirror[idx];
        end else begin
          res.status = 1'b1;
        end
      end
      default: ;
    endcase
    res.written     = 15'(count);
    res.shell_total = shell_tally;
    return res;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40) $display("mismatch in %s: got %0d, expected %0d", what, got, want);
  endtask

  // Drive input beats at the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        offered = cmd_backlog.pop_front();
        in_valid_i   <= 1'b1;
        command_i    <= offered.cmd;
        pos_z_i      <= offered.pz;
        pos_y_i      <= offered.py;
        pos_x_i      <= offered.px;
        radius_q4_i  <= offered.radius;
        second_q4_i  <= offered.extra;
        fill_label_i <= offered.fill;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Throttle the result side; hold off once for a long stretch.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    voxel_result_t want;
    bit            moved;
    in_taken = in_valid_i && in_ready_o;
    moved = in_taken || (out_valid_o && out_ready_i) || (psel && penable && pwrite && pready);
    if (rst_ni) begin
      if (in_taken) begin
        awaited_results.push_back(carve_or_read(offered));
        case (offered.cmd)
          CMD_SOLID: n_solid++;
          CMD_SHELL: n_shell++;
          CMD_READ:  n_read++;
          default:   n_unused++;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          flag_mismatch("beat with no result awaited", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (status_o !== want.status)
            flag_mismatch("status", status_o, want.status);
          if (read_label_o !== want.label)
            flag_mismatch("read_label", read_label_o, want.label);
          if (read_occupied_o !== want.occ)
            flag_mismatch("read_occupied", read_occupied_o, want.occ);
          if (voxels_written_o !== want.written)
            flag_mismatch("voxels_written", voxels_written_o, want.written);
          if (shell_total_o !== want.shell_total)
            flag_mismatch("shell_total", shell_total_o, want.shell_total);
        end
      end
    end
    stall_cycles <= moved ? 0 : stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("voxel_sphere_and_shell_carver regression: fail");
    $finish;
  end

  task automatic set_extent(int which, int value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(4 * which);
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (which)
      REG_EXTENT_Z: ext_z = 6'(value);
      REG_EXTENT_Y: ext_y = 6'(value);
      default:      ext_x = 6'(value);
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_volume(int z, int y, int x);
    set_extent(REG_EXTENT_Z, z);
    set_extent(REG_EXTENT_Y, y);
    set_extent(REG_EXTENT_X, x);
    n_settings++;
  endtask

  task automatic wait_quiet();
    while (cmd_backlog.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic void push_cmd(cmd_e c, int z, int y, int x, int r, int s, int f);
    voxel_cmd_t item;
    item.cmd    = c;
    item.pz     = 7'(z);
    item.py     = 7'(y);
    item.px     = 7'(x);
    item.radius = 8'(r);
    item.extra  = 8'(s);
    item.fill   = 8'(f);
    cmd_backlog.push_back(item);
  endfunction

  function automatic int random_coord(int eff, int around);
    int pick, v;
    pick = $urandom_range(99);
    if (pick < 10) return int'($urandom_range(95)) - 32;
    if (pick < 55) begin
      v = around + int'($urandom_range(6)) - 3;
      return (v < -32) ? -32 : ((v > 63) ? 63 : v);
    end
    return int'($urandom_range(eff + 3)) - 2;
  endfunction

  function automatic void push_random();
    int pick, z, y, x, r, s;
    cmd_e c;
    pick = $urandom_range(99);
    c = (pick < 35) ? CMD_READ : (pick < 65) ? CMD_SOLID : (pick < 95) ? CMD_SHELL : CMD_NONE;
    z = random_coord(effective(ext_z), recent_z);
    y = random_coord(effective(ext_y), recent_y);
    x = random_coord(effective(ext_x), recent_x);
    r = $urandom_range(255);
    s = $urandom_range(255);
    if (c == CMD_SOLID || c == CMD_SHELL) begin
      pick = $urandom_range(99);
      if (pick < 4)       r = $urandom_range(255, 200);
      else if (pick < 14) r = $urandom_range(140, 57);
      else                r = $urandom_range(56);
      if (c == CMD_SHELL && $urandom_range(1) == 0) s = $urandom_range(24);
      recent_z = z;
      recent_y = y;
      recent_x = x;
    end
    push_cmd(c, z, y, x, r, s, $urandom_range(255));
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_gap_pct = 28;
    recv_gap_pct = 82;
    set_volume(32, 32, 32);
    push_cmd(CMD_READ,    0,   0,   0,   0,   0,   0);
    push_cmd(CMD_READ,   31,  31,  31, 255, 255, 255);
    push_cmd(CMD_READ,  -32,   5,   5,   0,   0,   0);
    push_cmd(CMD_READ,   63,  63,  63,   0,   0,   0);
    push_cmd(CMD_READ,    5,  32,   5,   0,   0,   0);
    push_cmd(CMD_READ,    5,   5,  -1,   0,   0,   0);
    push_cmd(CMD_SOLID,  16,  16,  16,   0,   0, 255);
    push_cmd(CMD_READ,   16,  16,  16,   0,   0,   0);
    push_cmd(CMD_SOLID,   4,   4,   4,   7,   7,   1);
    push_cmd(CMD_SOLID,   8,   8,   8,   8,   8,   2);
    push_cmd(CMD_SOLID,  16,  16,  16, 255, 255, 165);
    push_cmd(CMD_READ,   16,  16,  31,   0,   0,   0);
    push_cmd(CMD_READ,    0,   0,   0,   0,   0,   0);
    push_cmd(CMD_SHELL,  16,  16,  16,  80,  16,  90);
    push_cmd(CMD_SHELL,   0,   0,   0,  48,  16,  51);
    push_cmd(CMD_SHELL,   2,   2,   2,  40, 255,  68);
    push_cmd(CMD_SHELL,  30,   2,  30,   0,   0,  17);
    push_cmd(CMD_SHELL,  28,   4,  28, 255,   1, 119);
    push_cmd(CMD_SOLID,  -2,  -2,  -2,  48,  24,   0);
    push_cmd(CMD_READ,    0,   0,   0,   0,   0,   0);
    push_cmd(CMD_SOLID,  63,  63,  63,  48,  48,   9);
    push_cmd(CMD_NONE,   63, -32,   7, 255, 255, 255);
    push_cmd(CMD_READ,    2,   2,   2,   0,   0,   0);
    push_cmd(CMD_READ,   30,   2,  30,   0,   0,   0);
    push_cmd(CMD_SHELL, -32, -32, -32,  16,   0,   3);
    wait_quiet();

    set_volume(7, 5, 9);
    recent_z = 3;
    recent_y = 2;
    recent_x = 4;
    for (int i = 0; i < 35; i++) push_random();
    wait_quiet();

    send_gap_pct = 82;
    recv_gap_pct = 28;
    set_volume(1, 32, 63);
    for (int i = 0; i < 28; i++) push_random();
    wait_quiet();

    set_volume(0, 20, 20);
    for (int i = 0; i < 8; i++) push_random();
    wait_quiet();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_volume(32, 20, 13);
    recent_z = 16;
    recent_y = 10;
    recent_x = 6;
    for (int i = 0; i < 30; i++) push_random();
    wait_quiet();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d solid, %0d shell, %0d read and %0d unused commands",
             n_solid, n_shell, n_read, n_unused);
    $display("across %0d volume shapes; %0d results checked, %0d mismatches",
             n_settings, results_seen, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("voxel_sphere_and_shell_carver regression: pass");
    end else begin
      $display("voxel_sphere_and_shell_carver regression: fail");
    end
    $finish;
  end

endmodule
